@@ sv/cave_automaton_row_step_top_macros.svh @@
// Assertion macros for the cave automaton row step block.
// Used by the checker; expects clk and arst_n in the scope of use.
`ifndef CAVE_AUTOMATON_ROW_STEP_TOP_MACROS_SVH
`define CAVE_AUTOMATON_ROW_STEP_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CAV_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define CAV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/cav_pkg.sv @@
// Shared types and constants of the cave automaton row step block.
// No dependencies; used by the interfaces and all modules.
package cav_pkg;

	localparam int ROW_W      = 64;
	localparam int THR_W      = 4;
	localparam int CNT_W      = 4;
	localparam int LEN_W      = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [THR_W-1:0] SURVIVE_MIN_RST = THR_W'(4);
	localparam logic [THR_W-1:0] BIRTH_MIN_RST   = THR_W'(5);
	localparam logic [LEN_W-1:0] ROW_LEN_RST     = LEN_W'(50);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SURVIVE_MIN = 2'd0,
		CFG_BIRTH_MIN   = 2'd1,
		CFG_ROW_LEN     = 2'd2
	} cfg_idx_t;

	// Bits one cell hands to its neighbors (off-grid columns read as alive)
	typedef struct packed {
		logic above;
		logic held;
		logic row;
	} cav_nbr_t;

	// Row-wide control shared by all cells
	typedef struct packed {
		logic load;
		logic fin;
		logic have_held;
	} cav_ctrl_t;

	// One result beat
	typedef struct packed {
		logic [ROW_W-1:0] next_row;
		logic             last;
	} res_beat_t;

endpackage

@@ sv/cav_row_if.sv @@
// Input row channel: valid/ready plus one grid row.
// Depends on cav_pkg.
interface cav_row_if;
	logic                      valid;
	logic                      ready;
	logic [cav_pkg::ROW_W-1:0] row_cells;
	logic                      final_row;

	modport source (output valid, output row_cells, output final_row, input ready);
	modport sink (input valid, input row_cells, input final_row, output ready);
endinterface

@@ sv/cav_res_if.sv @@
// Result channel: valid/ready plus one next-generation row.
// Depends on cav_pkg.
interface cav_res_if;
	logic                      valid;
	logic                      ready;
	logic [cav_pkg::ROW_W-1:0] next_row;
	logic                      last;

	modport source (output valid, output next_row, output last, input ready);
	modport sink (input valid, input next_row, input last, output ready);
endinterface

@@ sv/cav_cfg_if.sv @@
// Configuration write channel: valid/ready, register index and data.
// Depends on cav_pkg.
interface cav_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [cav_pkg::CFG_IDX_W-1:0]  index;
	logic [cav_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/cav_cell.sv @@
// One column cell: holds the above and held bits of its column and
// computes both candidate next-state bits from its neighbors. Depends on cav_pkg.
module cav_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cav_pkg::cav_ctrl_t        ctrl,
	input  logic [cav_pkg::THR_W-1:0] survive_min,
	input  logic [cav_pkg::THR_W-1:0] birth_min,
	input  logic                      in_use,
	input  logic                      row_bit,
	input  cav_pkg::cav_nbr_t         left,
	input  cav_pkg::cav_nbr_t         right,
	output cav_pkg::cav_nbr_t         mine,
	output logic                      mid_bit,
	output logic                      fin_bit
);
	import cav_pkg::*;

	logic             above_q;
	logic             held_q;
	logic [CNT_W-1:0] mid_cnt;
	logic [CNT_W-1:0] fin_cnt;
	logic             up_l;
	logic             up_c;
	logic             up_r;

	// Export effective bits; a column off the grid reads as alive
	assign mine.above = in_use ? above_q : 1'b1;
	assign mine.held  = in_use ? held_q  : 1'b1;
	assign mine.row   = in_use ? row_bit : 1'b1;

	// Held row with the row above and the incoming row below
	assign mid_cnt = CNT_W'(left.above) + CNT_W'(above_q) + CNT_W'(right.above)
		+ CNT_W'(left.held) + CNT_W'(right.held)
		+ CNT_W'(left.row) + CNT_W'(row_bit) + CNT_W'(right.row);

	// Incoming final row with border below; above is the held row if any
	assign up_l = ctrl.have_held ? left.held  : left.above;
	assign up_c = ctrl.have_held ? held_q     : above_q;
	assign up_r = ctrl.have_held ? right.held : right.above;
	assign fin_cnt = CNT_W'(up_l) + CNT_W'(up_c) + CNT_W'(up_r)
		+ CNT_W'(left.row) + CNT_W'(right.row) + CNT_W'(3);

	// Apply survive and birth rules, drop columns off the grid
	always_comb begin
		mid_bit = in_use & (held_q  ? (mid_cnt >= survive_min) : (mid_cnt >= birth_min));
		fin_bit = in_use & (row_bit ? (fin_cnt >= survive_min) : (fin_cnt >= birth_min));
	end

	// Advance the column state on each accepted row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_q <= 1'b1;
			held_q  <= 1'b0;
		end else if (ctrl.load) begin
			if (ctrl.fin) begin
				above_q <= 1'b1;
				held_q  <= 1'b0;
			end else begin
				if (ctrl.have_held) begin
					above_q <= held_q;
				end
				held_q <= row_bit;
			end
		end
	end

endmodule

@@ sv/cav_outq.sv @@
// Four-entry result queue taking up to two beats per cycle.
// Depends on cav_pkg.
module cav_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         push_n,
	input  cav_pkg::res_beat_t d0,
	input  cav_pkg::res_beat_t d1,
	output logic               has_room,
	output logic               out_valid,
	input  logic               out_ready,
	output cav_pkg::res_beat_t out_data
);
	import cav_pkg::*;

	res_beat_t  ent_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign has_room  = (cnt_q <= 3'd2);
	assign out_valid = (cnt_q != 3'd0);
	assign out_data  = ent_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	// Store pushed beats in order
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			ent_q[wr_ptr_q] <= d0;
		end
		if (push_n == 2'd2) begin
			ent_q[wr_ptr_q + 2'd1] <= d1;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n;
			rd_ptr_q <= rd_ptr_q + 2'(pop);
			cnt_q    <= cnt_q + 3'(push_n) - 3'(pop);
		end
	end

endmodule

@@ sv/cave_automaton_row_step_top.sv @@
// Cave automaton row step: one generation of a 3x3 binary automaton,
// streamed one row per beat, first row first.
//
// Channels: row (sink) takes row_cells and final_row; res (source) gives
// next_row and last; cfg (sink) writes survive_min (0), birth_min (1) and
// row_len (2). cfg.ready is always high; writes to other indexes are dropped.
// Each row after the first yields the result of the row before it; a final
// row yields its own result too, with last set, and the grid restarts.
// Throughput: one row per cycle while the queue has room. Every column is a
// cell that keeps both buffered rows and computes its bit from its neighbors
// in the same cycle. With the queue empty, res.valid rises in the cycle after
// the beat that causes it; a second beat follows once the first is taken.
// A final row after a held row pushes two beats; a four-entry result
// queue keeps row.ready high while it holds two beats or fewer, so a
// receiver taking one beat per cycle sees no input stall.
// Stalls: when res.ready is low, results wait in the queue and row.ready
// drops once more than two beats are waiting.
// Reset: registers return to 4, 5 and 50, no row is held, queue empty.
module cave_automaton_row_step_top #(
	parameter int MAX_ROW_LEN = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	cav_row_if.sink   row,
	cav_res_if.source res,
	cav_cfg_if.sink   cfg
);
	import cav_pkg::*;

	logic [THR_W-1:0] survive_min_q;
	logic [THR_W-1:0] birth_min_q;
	logic [LEN_W-1:0] row_len_q;
	logic             have_held_q;
	cav_ctrl_t        ctrl;
	logic [ROW_W-1:0] mid_row;
	logic [ROW_W-1:0] fin_row;
	cav_nbr_t         nbr [MAX_ROW_LEN+2];
	res_beat_t        beat0;
	res_beat_t        beat1;
	res_beat_t        head;
	logic [1:0]       push_n;
	logic             has_room;

	// Configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			survive_min_q <= SURVIVE_MIN_RST;
			birth_min_q   <= BIRTH_MIN_RST;
			row_len_q     <= ROW_LEN_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_SURVIVE_MIN: survive_min_q <= cfg.data[THR_W-1:0];
				CFG_BIRTH_MIN:   birth_min_q   <= cfg.data[THR_W-1:0];
				CFG_ROW_LEN:     row_len_q     <= cfg.data[LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Row-wide control
	assign row.ready      = has_room;
	assign ctrl.load      = row.valid && has_room;
	assign ctrl.fin       = row.final_row;
	assign ctrl.have_held = have_held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_held_q <= 1'b0;
		end else if (ctrl.load) begin
			have_held_q <= !row.final_row;
		end
	end

	// Border cells on both ends read as alive
	assign nbr[0]             = '1;
	assign nbr[MAX_ROW_LEN+1] = '1;

	// Chain of column cells
	for (genvar c = 0; c < MAX_ROW_LEN; c++) begin : g_cell
		logic in_use;
		assign in_use = (c == 0) || (LEN_W'(c) < row_len_q);

		cav_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.survive_min (survive_min_q),
			.birth_min   (birth_min_q),
			.in_use      (in_use),
			.row_bit     (row.row_cells[c]),
			.left        (nbr[c]),
			.right       (nbr[c+2]),
			.mine        (nbr[c+1]),
			.mid_bit     (mid_row[c]),
			.fin_bit     (fin_row[c])
		);
	end

	// Columns beyond the cell chain stay zero
	if (MAX_ROW_LEN < ROW_W) begin : g_pad
		assign mid_row[ROW_W-1:MAX_ROW_LEN] = '0;
		assign fin_row[ROW_W-1:MAX_ROW_LEN] = '0;
	end

	// Order the beats this row causes
	always_comb begin
		beat1.next_row = fin_row;
		beat1.last     = 1'b1;
		if (have_held_q) begin
			beat0.next_row = mid_row;
			beat0.last     = 1'b0;
		end else begin
			beat0 = beat1;
		end
		push_n = ctrl.load ? (2'(have_held_q) + 2'(row.final_row)) : 2'd0;
	end

	cav_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.d0        (beat0),
		.d1        (beat1),
		.has_room  (has_room),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.out_data  (head)
	);

	assign res.next_row = head.next_row;
	assign res.last     = head.last;

endmodule

@@ sv/cav_checker.sv @@
// Port-level checker for the cave automaton row step block, with its bind.
// Depends on cave_automaton_row_step_top_macros.svh and cav_pkg.
`include "cave_automaton_row_step_top_macros.svh"

module cav_checker #(
	parameter int MAX_ROW_LEN = 64
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      row_valid,
	input logic                      row_ready,
	input logic                      final_row,
	input logic                      res_valid,
	input logic                      res_ready,
	input logic [cav_pkg::ROW_W-1:0] next_row,
	input logic                      cfg_valid,
	input logic                      cfg_ready
);
	import cav_pkg::*;

	// A waiting result beat stays until taken
	`CAV_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result beat dropped")

	// A final row always leaves a result beat in the next cycle
	`CAV_ASSERT_NEXT(a_fin_result, row_valid && row_ready && final_row, res_valid, "final row gave no result")

	// Columns beyond the cell chain are never set
	`CAV_ASSERT_NOW(a_high_zero, res_valid, (next_row >> MAX_ROW_LEN) == '0, "bits beyond row set")

	// Configuration writes are never stalled
	`CAV_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "configuration write stalled")

endmodule

bind cave_automaton_row_step_top cav_checker #(.MAX_ROW_LEN(MAX_ROW_LEN)) u_cav_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.row_valid (row.valid),
	.row_ready (row.ready),
	.final_row (row.final_row),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.next_row  (res.next_row),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready)
);

@@ bench/cave_automaton_row_step_top_test.sv @@
`timescale 1ns / 1ps
// Testbench for cave_automaton_row_step_top: streams grids one row per beat and checks
// every next-generation row against an in-bench model of the cave automaton.
// Depends on cav_pkg, the cav_row_if, cav_res_if and cav_cfg_if interfaces and the RTL.
module cave_automaton_row_step_top_test;
	import cav_pkg::*;

	localparam int MAX_LEN      = ROW_W;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int HOLDOFF_LEN  = 150;
	localparam int RANDOM_ROWS  = 1850;
	localparam int DRAIN_CYCLES = 4;
	localparam int MAX_REPORTS  = 100;
	// Index with no register behind it; the block drops writes to it
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic [ROW_W-1:0] cells;
		logic             fin;
	} row_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Block inputs, all known from time zero
	logic                  row_valid = 1'b0;
	logic [ROW_W-1:0]      row_cells = '0;
	logic                  row_fin   = 1'b0;
	logic                  res_ready = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	cav_row_if row_ch();
	cav_res_if res_ch();
	cav_cfg_if cfg_ch();

	assign row_ch.valid     = row_valid;
	assign row_ch.row_cells = row_cells;
	assign row_ch.final_row = row_fin;
	assign res_ch.ready     = res_ready;
	assign cfg_ch.valid     = cfg_valid;
	assign cfg_ch.index     = cfg_index;
	assign cfg_ch.data      = cfg_data;

	cave_automaton_row_step_top #(
		.MAX_ROW_LEN(MAX_LEN)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.row   (row_ch),
		.res   (res_ch),
		.cfg   (cfg_ch)
	);

	// Automaton settings and grid state as the block should hold them
	logic [THR_W-1:0] survive_thr = SURVIVE_MIN_RST;
	logic [THR_W-1:0] birth_thr   = BIRTH_MIN_RST;
	logic [LEN_W-1:0] row_len_cfg = ROW_LEN_RST;
	logic [ROW_W-1:0] above_cells = '1;
	logic [ROW_W-1:0] held_cells  = '0;
	logic             held_valid  = 1'b0;

	row_beat_t row_beats_q[$];
	res_beat_t next_gen_q[$];

	int   error_count = 0;
	int   rows_queued = 0;
	int   cycle_count = 0;
	logic steady      = 1'b0;
	logic holdoff_req = 1'b0;

	// Sender and receiver pacing
	int          gap_left     = 0;
	int          burst_left   = 0;
	row_beat_t   send_beat;
	int          holdoff_left = 0;
	logic        holdoff_done = 1'b0;
	logic [15:0] stall_bits   = '1;
	int          stall_pos    = 0;
	res_beat_t   want;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Off-grid positions count as alive neighbors
	function automatic int alive_at(input logic [ROW_W-1:0] cells, input int col, input int len);
		if (col < 0 || col >= len)
			return 1;
		return int'(cells[col]);
	endfunction

	// Next generation of mid, with up and down as its neighbor rows
	function automatic logic [ROW_W-1:0] evolve_row(input logic [ROW_W-1:0] up,
		input logic [ROW_W-1:0] mid, input logic [ROW_W-1:0] down);
		int               len;
		int               cnt;
		int               c;
		int               d;
		logic [ROW_W-1:0] gen;
		if (row_len_cfg == 0)
			len = 1;
		else if (row_len_cfg > MAX_LEN)
			len = MAX_LEN;
		else
			len = int'(row_len_cfg);
		gen = '0;
		for (c = 0; c < len; c++) begin
			cnt = 0;
			for (d = -1; d <= 1; d++) begin
				cnt += alive_at(up, c + d, len) + alive_at(down, c + d, len);
				if (d != 0)
					cnt += alive_at(mid, c + d, len);
			end
			gen[c] = mid[c] ? (cnt >= survive_thr) : (cnt >= birth_thr);
		end
		return gen;
	endfunction

	// Advance the grid by one accepted row and queue the rows it completes
	function automatic void step_grid(input logic [ROW_W-1:0] cells, input logic fin);
		res_beat_t gen;
		if (held_valid) begin
			gen.next_row = evolve_row(above_cells, held_cells, cells);
			gen.last     = 1'b0;
			next_gen_q.push_back(gen);
			above_cells = held_cells;
		end
		held_cells = cells;
		held_valid = 1'b1;
		if (fin) begin
			gen.next_row = evolve_row(above_cells, held_cells, '1);
			gen.last     = 1'b1;
			next_gen_q.push_back(gen);
			above_cells = '1;
			held_cells  = '0;
			held_valid  = 1'b0;
		end
	endfunction

	function automatic void queue_row(input logic [ROW_W-1:0] cells, input logic fin);
		row_beat_t beat;
		beat.cells = cells;
		beat.fin   = fin;
		row_beats_q.push_back(beat);
		rows_queued++;
	endfunction

	// Mix sparse, dense and even rows so neighbor counts spread over 0..8
	function automatic logic [ROW_W-1:0] rand_cells();
		logic [ROW_W-1:0] a;
		logic [ROW_W-1:0] b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: return a & b;
			1: return a | b;
			default: return a;
		endcase
	endfunction

	// Threshold with random bits above the register width
	function automatic logic [CFG_DATA_W-1:0] pick_thr();
		logic [THR_W-1:0] thr;
		case ($urandom_range(0, 5))
			0: thr = '0;
			1: thr = THR_W'(8);
			2: thr = '1;
			3: thr = THR_W'(9);
			default: thr = THR_W'($urandom_range(0, 8));
		endcase
		return CFG_DATA_W'({$urandom_range(0, 7), thr});
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_len();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return CFG_DATA_W'(1);
			2: return CFG_DATA_W'(2);
			3: return CFG_DATA_W'(3);
			4: return CFG_DATA_W'(MAX_LEN);
			5: return CFG_DATA_W'($urandom_range(MAX_LEN + 1, 127));
			default: return CFG_DATA_W'($urandom_range(4, MAX_LEN - 1));
		endcase
	endfunction

	// Write one register; call right after a rising edge
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (idx)
			CFG_SURVIVE_MIN: survive_thr = val[THR_W-1:0];
			CFG_BIRTH_MIN:   birth_thr   = val[THR_W-1:0];
			CFG_ROW_LEN:     row_len_cfg = val[LEN_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait until every queued row is in and every result is out, then let the block go quiet
	task automatic settle();
		while (row_beats_q.size() != 0 || row_valid || next_gen_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Sender: feed queued rows in bursts separated by idle gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (row_valid && row_ch.ready)
				step_grid(row_cells, row_fin);
			if (!row_valid || row_ch.ready) begin
				if (gap_left != 0 && !steady) begin
					gap_left--;
					row_valid <= 1'b0;
				end else if (row_beats_q.size() != 0) begin
					send_beat = row_beats_q.pop_front();
					row_valid <= 1'b1;
					row_cells <= send_beat.cells;
					row_fin   <= send_beat.fin;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 16);
						gap_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12)
							: $urandom_range(0, 3);
					end
				end else begin
					row_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each result beat, then pick ready for the next cycle
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ready) begin
				if (next_gen_q.size() == 0) begin
					if (error_count < MAX_REPORTS)
						$display("%0t: unexpected result beat, actual next_row %h last %b",
							$time, res_ch.next_row, res_ch.last);
					error_count++;
				end else begin
					want = next_gen_q.pop_front();
					if (res_ch.next_row !== want.next_row) begin
						if (error_count < MAX_REPORTS)
							$display("%0t: next_row expected %h actual %h",
								$time, want.next_row, res_ch.next_row);
						error_count++;
					end
					if (res_ch.last !== want.last) begin
						if (error_count < MAX_REPORTS)
							$display("%0t: last expected %b actual %b",
								$time, want.last, res_ch.last);
						error_count++;
					end
				end
			end
			// Long hold-off once on request, else steady or patterned stalls
			if (holdoff_left != 0) begin
				holdoff_left--;
				res_ready <= 1'b0;
			end else if (holdoff_req && !holdoff_done) begin
				holdoff_done = 1'b1;
				holdoff_left = HOLDOFF_LEN;
				res_ready <= 1'b0;
			end else if (steady) begin
				res_ready <= 1'b1;
			end else begin
				res_ready <= stall_bits[stall_pos];
				if (stall_pos == 15) begin
					stall_pos = 0;
					case ($urandom_range(0, 3))
						0: stall_bits = 16'($urandom & $urandom);
						1: stall_bits = 16'($urandom | $urandom);
						2: stall_bits = '1;
						default: stall_bits = 16'($urandom);
					endcase
				end else begin
					stall_pos++;
				end
			end
		end
	end

	// Guard against a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int start_count;
		int phase;
		int phase_rows;
		int grid_h;
		int r;
		int i;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: single-row grids, all dead and all alive
		queue_row('0, 1'b1);
		queue_row('1, 1'b1);
		// Three-row grid
		queue_row('0, 1'b0);
		queue_row('1, 1'b0);
		queue_row({32{2'b10}}, 1'b1);
		// Only bits beyond the row length set, then only bits inside it
		queue_row(64'hFFFC_0000_0000_0000, 1'b0);
		queue_row(64'h0003_FFFF_FFFF_FFFF, 1'b1);
		// Checkerboard
		queue_row({32{2'b01}}, 1'b0);
		queue_row({32{2'b10}}, 1'b1);
		settle();

		// Zero thresholds, zero row length acts as one cell
		write_reg(CFG_SURVIVE_MIN, '0);
		write_reg(CFG_BIRTH_MIN, '0);
		write_reg(CFG_ROW_LEN, '0);
		queue_row('0, 1'b0);
		queue_row('0, 1'b1);
		settle();

		// Survive above eight never fires, birth needs eight; oversized row length clamps to max
		write_reg(CFG_SURVIVE_MIN, CFG_DATA_W'(15));
		write_reg(CFG_BIRTH_MIN, CFG_DATA_W'(8));
		write_reg(CFG_ROW_LEN, '1);
		queue_row('1, 1'b0);
		queue_row({32{2'b01}}, 1'b0);
		queue_row('0, 1'b1);
		settle();

		write_reg(CFG_SURVIVE_MIN, CFG_DATA_W'(8));
		write_reg(CFG_BIRTH_MIN, CFG_DATA_W'(9));
		write_reg(CFG_ROW_LEN, CFG_DATA_W'(MAX_LEN));
		queue_row('1, 1'b1);
		queue_row(64'h8000_0000_0000_0001, 1'b0);
		queue_row('1, 1'b1);
		settle();

		write_reg(CFG_SURVIVE_MIN, CFG_DATA_W'(3));
		write_reg(CFG_BIRTH_MIN, CFG_DATA_W'(3));
		write_reg(CFG_ROW_LEN, CFG_DATA_W'(MAX_LEN + 1));
		queue_row({16{4'h0, 4'hF}}, 1'b1);
		settle();

		write_reg(CFG_ROW_LEN, CFG_DATA_W'(2));
		queue_row(64'h1, 1'b0);
		queue_row(64'h2, 1'b1);
		settle();

		// Dropped write, then a register change in the middle of a grid
		write_reg(CFG_ROW_LEN, CFG_DATA_W'(3));
		write_reg(CFG_UNUSED, '1);
		queue_row(64'h5, 1'b0);
		settle();
		write_reg(CFG_SURVIVE_MIN, CFG_DATA_W'(2));
		queue_row(64'h2, 1'b1);

		// Random phases: new settings, then mostly well-formed grids with some stray rows
		start_count = rows_queued;
		phase = 0;
		while (rows_queued - start_count < RANDOM_ROWS) begin
			settle();
			write_reg(CFG_SURVIVE_MIN, pick_thr());
			write_reg(CFG_BIRTH_MIN, pick_thr());
			write_reg(CFG_ROW_LEN, pick_len());
			steady      <= (phase == 2) || ($urandom_range(0, 4) == 0);
			holdoff_req <= (phase == 2);
			phase_rows = $urandom_range(40, 160);
			r = 0;
			while (r < phase_rows) begin
				if ($urandom_range(0, 9) == 0) begin
					queue_row(rand_cells(), 1'($urandom_range(0, 1)));
					r++;
				end else begin
					grid_h = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 20)
						: $urandom_range(1, 6);
					for (i = 0; i < grid_h; i++)
						queue_row(rand_cells(), i == grid_h - 1);
					r += grid_h;
				end
			end
			// Leave a grid open now and then so the next settings land mid-grid
			if ($urandom_range(0, 4) == 0)
				queue_row(rand_cells(), 1'b0);
			phase++;
		end

		settle();
		if (error_count == 0 && next_gen_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
